// File: design/rpc_pkg.sv
// Shared types and constants for the rudder position controller.
`default_nettype none

package rpc_pkg;

  typedef enum logic [1:0] {
    REQ_SET_TARGET = 2'd0,
    REQ_STOP       = 2'd1,
    REQ_JOG        = 2'd2,
    REQ_POSITION   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    CFG_DEADBAND  = 2'd0,
    CFG_JOG_LIMIT = 2'd1
  } cfg_code_t;

  localparam int unsigned DEADBAND_W  = 10;
  localparam int unsigned JOG_LIMIT_W = 14;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned SPEED_W     = 11;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 14;

  localparam logic [DEADBAND_W-1:0]  DEADBAND_RESET  = 10'd50;
  localparam logic [JOG_LIMIT_W-1:0] JOG_LIMIT_RESET = 14'd2900;

  localparam int SpeedMax = 1000;
  localparam int SpeedDiv = 6;
  // Error magnitude at which the rounded quotient reaches full speed.
  localparam int SatMag   = SpeedMax * SpeedDiv - SpeedDiv / 2;
  // floor(m / 6) == (m * DivRecip) >> DivShift for every m below 2**17.
  localparam int DivShift = 18;
  localparam int DivRecip = (1 << DivShift) / SpeedDiv + 1;

  typedef struct packed {
    req_code_t                  req_type;
    logic signed [ANGLE_W-1:0]  value;
    logic                       autopilot_engaged;
    logic signed [ANGLE_W-1:0]  rudder_angle;
  } req_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_cmd;
    logic                      settled;
  } res_t;

  // Outcome of the proportional law for one position report.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      in_band;
  } law_t;

endpackage

`default_nettype wire

// File: design/rpc_prop_law.sv
// Proportional position law: error, deadband test and scaled speed.
`default_nettype none

module rpc_prop_law (
  input  wire logic signed [rpc_pkg::ANGLE_W-1:0]     target_angle,
  input  wire logic signed [rpc_pkg::ANGLE_W-1:0]     position,
  input  wire logic        [rpc_pkg::DEADBAND_W-1:0]  deadband,
  output rpc_pkg::law_t                               law
);

  localparam int ErrW  = rpc_pkg::ANGLE_W + 1;
  localparam int MW    = 13;
  localparam int RecW  = 16;
  localparam int ProdW = MW + RecW;
  localparam int QW    = rpc_pkg::SPEED_W;

  logic signed [ErrW-1:0]        err;
  logic        [ErrW-1:0]        mag;
  logic                          sat;
  logic        [MW-1:0]          m;
  logic        [ProdW-1:0]       prod;
  logic        [QW-1:0]          q;
  logic        [QW-1:0]          sp;

  always_comb begin
    err  = ErrW'(target_angle) - ErrW'(position);
    mag  = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
    sat  = mag >= ErrW'(rpc_pkg::SatMag);
    // Round half away from zero: add half the divisor before the floor divide.
    m    = MW'(mag) + MW'(rpc_pkg::SpeedDiv / 2);
    prod = ProdW'(m) * ProdW'(rpc_pkg::DivRecip);
    q    = prod[rpc_pkg::DivShift +: QW];
    if (sat) begin
      sp = QW'(rpc_pkg::SpeedMax);
    end else if (q == '0) begin
      sp = QW'(1);
    end else begin
      sp = q;
    end
    law.speed   = err[ErrW-1] ? $signed(-sp) : $signed(sp);
    law.in_band = mag < ErrW'(deadband);
  end

endmodule

`default_nettype wire

// File: design/rudder_position_controller_core.sv
// Rudder position controller: request decode, loop state and result register.
// A request accepted into the input register moves on, into the result register
// if it emits a result, once that register is free or its result is being taken.
// Throughput: one request per cycle; intake stalls only while both the input
// register and the result register are full and the result is stalled.
// Reset: synchronous, clears both stages, the loop state and target, and
// loads deadband = 50 and jog_limit = 2900.
`default_nettype none

module rudder_position_controller_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire rpc_pkg::req_t                       req_data,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output rpc_pkg::res_t                            res_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = rpc_pkg::ANGLE_W + 1;
  localparam int SW = rpc_pkg::SPEED_W;

  logic [rpc_pkg::DEADBAND_W-1:0]       deadband;
  logic [rpc_pkg::JOG_LIMIT_W-1:0]      jog_limit;
  logic signed [rpc_pkg::ANGLE_W-1:0]   target_angle;
  logic                                 loop_armed;
  logic                                 rudder_mode;

  logic                                 in_full;
  rpc_pkg::req_t                        in_req;
  logic                                 out_full;
  rpc_pkg::res_t                        out_res;

  logic                                 out_free;
  logic                                 advance;
  logic                                 accept;

  rpc_pkg::law_t                        law;
  logic                                 emit;
  rpc_pkg::res_t                        res_next;
  logic signed [AW-1:0]                 lim;
  logic signed [AW-1:0]                 angle;
  logic                                 jog_ok;
  logic signed [SW-1:0]                 jog_speed;

  assign cfg_ready = 1'b1;

  assign out_free  = !out_full || !res_stall;
  assign advance   = in_full && out_free;
  assign req_stall = in_full && !out_free;
  assign accept    = req_valid && !req_stall;
  assign res_valid = out_full;
  assign res_data  = out_res;

  rpc_prop_law u_law (
    .target_angle (target_angle),
    .position     (in_req.value),
    .deadband     (deadband),
    .law          (law)
  );

  always_comb begin
    lim    = AW'($signed({1'b0, jog_limit}));
    angle  = AW'(in_req.rudder_angle);
    jog_ok = !in_req.autopilot_engaged &&
             ((in_req.value > 0 && angle < lim) || (in_req.value < 0 && angle > -lim));
    // Clamp jog speed to full scale either way.
    if (in_req.value > rpc_pkg::SpeedMax) begin
      jog_speed = SW'(rpc_pkg::SpeedMax);
    end else if (in_req.value < -rpc_pkg::SpeedMax) begin
      jog_speed = SW'(-rpc_pkg::SpeedMax);
    end else begin
      jog_speed = SW'(in_req.value);
    end

    emit     = 1'b0;
    res_next = '0;
    unique case (in_req.req_type)
      rpc_pkg::REQ_SET_TARGET: begin
        emit = 1'b0;
      end
      rpc_pkg::REQ_STOP: begin
        emit             = 1'b1;
        res_next.settled = 1'b1;
      end
      rpc_pkg::REQ_JOG: begin
        emit               = jog_ok;
        res_next.speed_cmd = jog_speed;
      end
      rpc_pkg::REQ_POSITION: begin
        emit = loop_armed && rudder_mode;
        if (law.in_band) begin
          res_next.settled = 1'b1;
        end else begin
          res_next.speed_cmd = law.speed;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband  <= rpc_pkg::DEADBAND_RESET;
      jog_limit <= rpc_pkg::JOG_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rpc_pkg::CFG_DEADBAND) begin
        deadband <= cfg_data[rpc_pkg::DEADBAND_W-1:0];
      end else if (cfg_index == rpc_pkg::CFG_JOG_LIMIT) begin
        jog_limit <= cfg_data[rpc_pkg::JOG_LIMIT_W-1:0];
      end
    end
  end

  // Input stage: hold the request until the result side can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (accept) begin
      in_req <= req_data;
    end
  end

  // Loop state changes as the request leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle <= '0;
      loop_armed   <= 1'b0;
      rudder_mode  <= 1'b0;
    end else if (advance) begin
      if (in_req.req_type == rpc_pkg::REQ_SET_TARGET) begin
        target_angle <= in_req.value;
        loop_armed   <= 1'b1;
        rudder_mode  <= 1'b1;
      end else if (in_req.req_type == rpc_pkg::REQ_STOP) begin
        loop_armed <= 1'b0;
      end else if (in_req.req_type == rpc_pkg::REQ_POSITION && emit && law.in_band) begin
        loop_armed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_free) begin
      out_full <= advance && emit;
    end
    if (out_free && advance && emit) begin
      out_res <= res_next;
    end
  end

  a_settled_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.settled |-> res_data.speed_cmd == '0)
    else $error("settled result carries nonzero speed");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.speed_cmd <= SW'(rpc_pkg::SpeedMax) &&
                   res_data.speed_cmd >= SW'(-rpc_pkg::SpeedMax)))
    else $error("speed command out of range");

  a_armed_mode: assert property (@(posedge clk) disable iff (rst)
    loop_armed |-> rudder_mode)
    else $error("loop armed without rudder mode");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> in_full && res_valid && res_stall)
    else $error("request stalled without a blocked result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_full && !res_stall |=> !in_full || $past(accept))
    else $error("input stage failed to advance");

endmodule

`default_nettype wire

// File: test/tb_rudder_position_controller_core.sv
// Self-checking testbench for the rudder position controller core.
module tb_rudder_position_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rpc_pkg::*;

  localparam int FULL_SPEED = 1000;
  localparam int ERR_PER_STEP = 6;
  localparam int LONG_HOLD = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rudder_position_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Controller state and register copies used to predict each servo command.
  logic signed [ANGLE_W-1:0] held_target = '0;
  bit loop_on = 1'b0;
  bit target_seen = 1'b0;
  logic [DEADBAND_W-1:0] deadband_cfg = DEADBAND_RESET;
  logic [JOG_LIMIT_W-1:0] jog_limit_cfg = JOG_LIMIT_RESET;

  req_t pending_requests[$];
  res_t servo_cmds_due[$];
  int unsigned mismatches = 0;

  bit req_taken = 1'b0;
  bit res_taken = 1'b0;
  bit req_idle_on = 1'b1;
  bit res_idle_on = 1'b1;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;

  function automatic bit predict_servo_cmd(input req_t r, output res_t cmd);
    int val, ang, lim, err, mag, spd;
    bit emits;
    val = $signed(r.value);
    ang = $signed(r.rudder_angle);
    lim = int'(jog_limit_cfg);
    cmd = '0;
    emits = 1'b0;
    case (r.req_type)
      REQ_SET_TARGET: begin
        held_target = r.value;
        loop_on = 1'b1;
        target_seen = 1'b1;
      end
      REQ_STOP: begin
        loop_on = 1'b0;
        cmd.settled = 1'b1;
        emits = 1'b1;
      end
      REQ_JOG: begin
        if (!r.autopilot_engaged && ((val > 0 && ang < lim) || (val < 0 && ang > -lim))) begin
          spd = (val > FULL_SPEED) ? FULL_SPEED : ((val < -FULL_SPEED) ? -FULL_SPEED : val);
          cmd.speed_cmd = SPEED_W'(spd);
          emits = 1'b1;
        end
      end
      REQ_POSITION: begin
        if (loop_on && target_seen) begin
          err = held_target - val;
          mag = (err < 0) ? -err : err;
          emits = 1'b1;
          if (mag < int'(deadband_cfg)) begin
            loop_on = 1'b0;
            cmd.settled = 1'b1;
          end else begin
            // round half away from zero, then clamp to 1..full speed
            spd = (mag + ERR_PER_STEP / 2) / ERR_PER_STEP;
            if (spd > FULL_SPEED) spd = FULL_SPEED;
            if (spd < 1) spd = 1;
            cmd.speed_cmd = SPEED_W'((err < 0) ? -spd : spd);
          end
        end
      end
    endcase
    return emits;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned draw_wait(bit idle_on);
    return idle_on ? $urandom_range(0, 19) : 0;
  endfunction

  function automatic int rand_angle();
    return int'($urandom_range(0, 36000)) - 18000;
  endfunction

  // Sample both handshakes, predict accepted requests, check results.
  always @(posedge clk) begin
    res_t cmd;
    res_t due;
    req_taken <= !rst && req_valid && !req_stall;
    res_taken <= !rst && res_valid && !res_stall;
    if (!rst && req_valid && !req_stall) begin
      if (predict_servo_cmd(req_data, cmd)) servo_cmds_due.push_back(cmd);
    end
    if (!rst && res_valid && !res_stall) begin
      if (servo_cmds_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result speed %0d settled %0b",
                                  res_data.speed_cmd, res_data.settled));
      end else begin
        due = servo_cmds_due.pop_front();
        if (res_data.speed_cmd !== due.speed_cmd)
          report_mismatch($sformatf("speed_cmd %0d, expected %0d",
                                    res_data.speed_cmd, due.speed_cmd));
        if (res_data.settled !== due.settled)
          report_mismatch($sformatf("settled %0b, expected %0b",
                                    res_data.settled, due.settled));
      end
    end
  end

  // Request driver: hold a stalled request, else wait out the gap and send the next.
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap--;
      end else if (pending_requests.size() > 0) begin
        req_data <= pending_requests.pop_front();
        req_valid <= 1'b1;
        send_gap = draw_wait(req_idle_on);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result stall: a random wait per result, or a long hold when asked.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD;
      res_stall <= 1'b1;
    end else begin
      if (res_taken) stall_left = draw_wait(res_idle_on);
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic queue_request(req_code_t code, int val, bit engaged, int ang);
    req_t r;
    r.req_type = code;
    r.value = val[ANGLE_W-1:0];
    r.autopilot_engaged = engaged;
    r.rudder_angle = ang[ANGLE_W-1:0];
    pending_requests.push_back(r);
  endtask

  task automatic write_register(cfg_code_t idx, int unsigned data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEADBAND) deadband_cfg = DEADBAND_W'(data);
    else jog_limit_cfg = JOG_LIMIT_W'(data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is sent and every result is back, then let the pipe empty.
  task automatic settle_block();
    while (pending_requests.size() > 0 || req_valid || servo_cmds_due.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly target-then-approach sequences, plus jogs near the limit, stops and noise.
  task automatic queue_random_requests(int unsigned n);
    int unsigned sent;
    int unsigned steps;
    int r, tgt, span, val, ang, lim;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      lim = int'(jog_limit_cfg);
      if (r < 55) begin
        tgt = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 65535)) : rand_angle();
        queue_request(REQ_SET_TARGET, tgt, $urandom_range(0, 1), rand_angle());
        sent++;
        steps = $urandom_range(1, 8);
        span = (r < 20) ? 40000 : ((r < 40) ? 7000 : int'(deadband_cfg) + 4);
        repeat (steps) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_request(REQ_STOP, rand_angle(), $urandom_range(0, 1), rand_angle());
          end else begin
            val = tgt + int'($urandom_range(0, 2 * span)) - span;
            queue_request(REQ_POSITION, val, $urandom_range(0, 1), rand_angle());
          end
          sent++;
          // close in on the target
          span = span / 2 + 1;
        end
      end else if (r < 80) begin
        case ($urandom_range(0, 9))
          0: val = 0;
          1, 2: val = $urandom_range(0, 65535);
          default: val = int'($urandom_range(0, 2400)) - 1200;
        endcase
        if ($urandom_range(0, 1) == 1) ang = ((val[15] == 1'b0) ? lim : -lim) +
                                               int'($urandom_range(0, 4)) - 2;
        else ang = rand_angle();
        queue_request(REQ_JOG, val, $urandom_range(0, 3) == 0, ang);
        sent++;
      end else if (r < 88) begin
        queue_request(REQ_STOP, rand_angle(), $urandom_range(0, 1), rand_angle());
        sent++;
      end else if (r < 94) begin
        queue_request(REQ_POSITION, rand_angle(), $urandom_range(0, 1), rand_angle());
        sent++;
      end else begin
        queue_request(req_code_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
                      $urandom_range(0, 1), $urandom_range(0, 65535));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned db_set[8];
    int unsigned jl_set[8];
    db_set = '{1000, 1023, 1, 0, 0, 50, 0, 300};
    jl_set = '{9000, 16383, 1, 2900, 0, 0, 0, 9000};
    db_set[4] = $urandom_range(0, 1000);
    db_set[6] = $urandom_range(0, 1000);
    jl_set[4] = $urandom_range(0, 9000);
    jl_set[6] = $urandom_range(0, 9000);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset register values: jog limits, loop before any target, deadband edges.
    queue_request(REQ_POSITION, -18000, 0, 0);
    queue_request(REQ_JOG, 500, 1, 0);
    queue_request(REQ_JOG, 0, 0, 0);
    queue_request(REQ_JOG, 18000, 0, -18000);
    queue_request(REQ_JOG, -18000, 0, 18000);
    queue_request(REQ_JOG, 500, 0, 2900);
    queue_request(REQ_JOG, 500, 0, 2899);
    queue_request(REQ_JOG, -500, 0, -2900);
    queue_request(REQ_JOG, -500, 0, -2899);
    queue_request(REQ_STOP, 0, 0, 0);
    queue_request(REQ_SET_TARGET, 18000, 1, -18000);
    queue_request(REQ_POSITION, -18000, 1, 0);
    queue_request(REQ_POSITION, 17951, 0, 0);
    queue_request(REQ_POSITION, 0, 0, 0);
    queue_request(REQ_SET_TARGET, -18000, 0, 18000);
    queue_request(REQ_POSITION, 18000, 0, 0);
    queue_request(REQ_POSITION, -17950, 0, 0);
    queue_request(REQ_POSITION, -17951, 0, 0);
    queue_request(REQ_SET_TARGET, 0, 0, 0);
    queue_request(REQ_STOP, 0, 0, 0);
    queue_request(REQ_POSITION, 5000, 0, 0);
    settle_block();

    // Zero deadband and zero jog limit: minimum speed, rounding, full-speed knee.
    write_register(CFG_DEADBAND, 0);
    write_register(CFG_JOG_LIMIT, 0);
    queue_request(REQ_JOG, 1, 0, 0);
    queue_request(REQ_JOG, 1, 0, -1);
    queue_request(REQ_JOG, -1, 0, 1);
    queue_request(REQ_SET_TARGET, 100, 0, 0);
    queue_request(REQ_POSITION, 100, 0, 0);
    queue_request(REQ_POSITION, 97, 0, 0);
    queue_request(REQ_POSITION, 91, 0, 0);
    queue_request(REQ_POSITION, 106, 0, 0);
    queue_request(REQ_POSITION, -5897, 0, 0);
    queue_request(REQ_POSITION, -5896, 0, 0);
    settle_block();

    // Hold results off while requests keep coming, so the input backs up.
    req_idle_on = 1'b0;
    res_idle_on = 1'b1;
    holds_asked++;
    repeat (20) begin
      queue_request(REQ_STOP, rand_angle(), 0, 0);
      queue_request(REQ_JOG, int'($urandom_range(1, 1000)), 0, -1);
    end
    settle_block();

    for (int p = 0; p < 8; p++) begin
      write_register(CFG_DEADBAND, db_set[p]);
      write_register(CFG_JOG_LIMIT, jl_set[p]);
      req_idle_on = (p % 4 == 0) || (p % 4 == 2);
      res_idle_on = (p % 4 == 0) || (p % 4 == 3);
      queue_random_requests(120);
      // pause the sender until all results are back
      if (p == 3) settle_block();
      queue_random_requests(120);
      settle_block();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TIMEOUT: requests or results stopped moving");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
design/rpc_pkg.sv
design/rpc_prop_law.sv
design/rudder_position_controller_core.sv
test/tb_rudder_position_controller_core.sv
